// ===== rtl/pcba_pkg.sv =====
// ----------------------------------------------------------------------------
// pcba_pkg
// Shared constants, codes and types of the paged cache block allocator.
// ----------------------------------------------------------------------------
package pcba_pkg;

  localparam int TOTAL_BLOCKS           = 4096;
  localparam int MAX_REQUESTS           = 256;
  localparam int MAX_BLOCKS_PER_REQUEST = 64;

  localparam int BLK_W   = 12;   // block id
  localparam int TOT_W   = 13;   // free block count
  localparam int SLOT_W  = 8;
  localparam int LEN_W   = 15;
  localparam int EIDX_W  = 6;
  localparam int CNT_W   = 7;
  localparam int BS_W    = 9;
  localparam int VAL_W   = 20;

  // Actions.
  localparam logic [2:0] ACT_ALLOC      = 3'd0;
  localparam logic [2:0] ACT_APPEND_TOK = 3'd1;
  localparam logic [2:0] ACT_APPEND_BLK = 3'd2;
  localparam logic [2:0] ACT_RELEASE    = 3'd3;
  localparam logic [2:0] ACT_MAP_SLOT   = 3'd4;
  localparam logic [2:0] ACT_READ_ENTRY = 3'd5;

  // Statuses.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EXISTS  = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_NOFREE  = 3'd3;
  localparam logic [2:0] ST_BADARG  = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TOK_PER_BLK = 2'd0;
  localparam logic [1:0] CFG_USABLE      = 2'd1;
  localparam logic [1:0] CFG_RESERVE     = 2'd2;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] dividend;
    logic [BS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] quot;
    logic [BS_W-1:0]  rem;
  } div_rsp_t;

endpackage

// ===== rtl/paged_cache_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// paged_cache_block_allocator_core
// Free block FIFO and per-request block lists kept in synchronous memories.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   action, request_slot, length,
//                                           token_count, entry_index
// out      output     out_valid / out_ready status, value, free_count, list_length
// cfg      input      cfg_wr_en             cfg_index, cfg_data
//
// One transaction at a time. Allocate runs a division, then pops its blocks; append tokens
// runs one or two divisions, then pops its blocks; release walks the listed blocks; map
// slot runs a division and a multiply; append block pops one block; read entry reads one
// list entry; a transaction rejected without a division is answered directly. The next
// transaction can be accepted after the result is registered; a held result only delays
// that registering. After reset and every configuration write the free FIFO is rewritten.
// ----------------------------------------------------------------------------
module paged_cache_block_allocator_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     in_action,
  input  logic [pcba_pkg::SLOT_W-1:0]    in_request_slot,
  input  logic [pcba_pkg::LEN_W-1:0]     in_length,
  input  logic [pcba_pkg::LEN_W-1:0]     in_token_count,
  input  logic [pcba_pkg::EIDX_W-1:0]    in_entry_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_status,
  output logic [pcba_pkg::VAL_W-1:0]     out_value,
  output logic [pcba_pkg::TOT_W-1:0]     out_free_count,
  output logic [pcba_pkg::CNT_W-1:0]     out_list_length,
  input  logic                           cfg_wr_en,
  input  logic [1:0]                     cfg_index,
  input  logic [12:0]                    cfg_data
);
  import pcba_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EVAL = 4'd1;
  localparam logic [3:0] S_DIV1 = 4'd2;
  localparam logic [3:0] S_DIV2 = 4'd3;
  localparam logic [3:0] S_POP  = 4'd4;
  localparam logic [3:0] S_PWR  = 4'd5;
  localparam logic [3:0] S_REL  = 4'd6;
  localparam logic [3:0] S_PUSH = 4'd7;
  localparam logic [3:0] S_RDB  = 4'd8;
  localparam logic [3:0] S_RDV  = 4'd9;
  localparam logic [3:0] S_MUL  = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  localparam int BADDR_W = SLOT_W + EIDX_W;

  // Configuration.
  logic [BS_W-1:0]  tok_per_blk_r;
  logic [12:0]      usable_r;
  logic [11:0]      reserve_r;
  logic             cfg_hit;
  logic [BS_W-1:0]  bs_eff;
  logic [13:0]      fill_sum;
  logic [TOT_W-1:0] fill;

  // Free FIFO.
  logic [BLK_W-1:0] fq_mem [TOTAL_BLOCKS];
  logic [BLK_W-1:0] fq_rd_r;
  logic             fq_we;
  logic [BLK_W-1:0] fq_waddr;
  logic [BLK_W-1:0] fq_wdata;
  logic [BLK_W-1:0] head_r;
  logic [BLK_W-1:0] tail_r;
  logic [TOT_W-1:0] free_total_r;
  logic             clr_busy_r;
  logic [BLK_W-1:0] clr_idx_r;

  // Request table.
  logic [BLK_W-1:0]   blk_mem [MAX_REQUESTS*MAX_BLOCKS_PER_REQUEST];
  logic [BLK_W-1:0]   blk_rd_r;
  logic               blk_we;
  logic [BADDR_W-1:0] blk_waddr;
  logic [BADDR_W-1:0] blk_raddr;
  logic [CNT_W-1:0]   cnt_mem [MAX_REQUESTS];
  logic [CNT_W-1:0]   cnt_rd_r;
  logic               cnt_we;
  logic [CNT_W-1:0]   cnt_wdata;
  logic [MAX_REQUESTS-1:0] req_valid_r;

  // Control.
  logic [3:0]        st_r;
  logic [2:0]        act_r;
  logic [SLOT_W-1:0] slot_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  tok_r;
  logic [EIDX_W-1:0] eidx_r;
  logic [CNT_W-1:0]  cnt_work_r;
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W-1:0]  idx_r;
  logic [BS_W-1:0]   off_r;
  logic [2:0]        status_r;
  logic [VAL_W-1:0]  value_r;
  logic              out_valid_r;
  logic [2:0]        o_status_r;
  logic [VAL_W-1:0]  o_value_r;
  logic [TOT_W-1:0]  o_free_r;
  logic [CNT_W-1:0]  o_len_r;

  logic              in_acc;
  logic              vld;
  logic [CNT_W-1:0]  cnt_eff;
  logic              eval_div;
  logic [16:0]       need;
  logic [16:0]       add;
  logic [BS_W-1:0]   rem_tok;
  logic              tok_over;
  logic [20:0]       slot_addr;
  div_req_t          dreq;
  div_rsp_t          drsp;

  assign cfg_hit  = cfg_wr_en && (cfg_index == CFG_TOK_PER_BLK || cfg_index == CFG_USABLE ||
                                  cfg_index == CFG_RESERVE);
  assign bs_eff   = (tok_per_blk_r == '0) ? BS_W'(1) :
                    (tok_per_blk_r > BS_W'(256)) ? BS_W'(256) : tok_per_blk_r;
  assign fill_sum = {1'b0, usable_r} + {2'b0, reserve_r};
  assign fill     = (fill_sum > 14'(TOTAL_BLOCKS)) ? TOT_W'(TOTAL_BLOCKS) : fill_sum[TOT_W-1:0];

  assign in_ready = (st_r == S_IDLE) && !clr_busy_r;
  assign in_acc   = in_valid && in_ready;

  assign vld     = req_valid_r[slot_r];
  assign cnt_eff = vld ? cnt_rd_r : '0;

  // Quantities that follow a division.
  assign need     = {2'b0, drsp.quot} + 17'(drsp.rem != '0);
  assign add      = {2'b0, drsp.quot} + 17'd1;
  assign rem_tok  = (drsp.rem == '0) ? '0 : bs_eff - drsp.rem;
  assign tok_over = tok_r > {6'b0, rem_tok};

  assign eval_div = ((act_r == ACT_ALLOC) && !vld && len_r != '0) ||
                    ((act_r == ACT_APPEND_TOK) && tok_r != '0 && vld && len_r != '0) ||
                    ((act_r == ACT_MAP_SLOT) && vld && len_r != '0);

  always_comb begin
    dreq.start    = 1'b0;
    dreq.divisor  = bs_eff;
    dreq.dividend = (act_r == ACT_MAP_SLOT) ? len_r - LEN_W'(1) : len_r;
    if (st_r == S_EVAL && eval_div) begin
      dreq.start = 1'b1;
    end else if (st_r == S_DIV1 && drsp.done && act_r == ACT_APPEND_TOK && tok_over) begin
      dreq.start    = 1'b1;
      dreq.dividend = tok_r - {6'b0, rem_tok} - LEN_W'(1);
    end
  end

  pcba_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // Memory ports.
  assign fq_we     = clr_busy_r || (st_r == S_PUSH && free_total_r < TOT_W'(TOTAL_BLOCKS));
  assign fq_waddr  = clr_busy_r ? clr_idx_r : tail_r;
  assign fq_wdata  = clr_busy_r ? clr_idx_r : blk_rd_r;
  assign blk_we    = (st_r == S_PWR);
  assign blk_waddr = {slot_r, cnt_work_r[EIDX_W-1:0]};
  assign blk_raddr = {slot_r, idx_r[EIDX_W-1:0]};
  assign cnt_we    = (st_r == S_PWR && n_r == CNT_W'(1)) ||
                     (st_r == S_REL && idx_r == cnt_work_r);
  assign cnt_wdata = (st_r == S_PWR) ? cnt_work_r + CNT_W'(1) : '0;
  assign slot_addr = 21'(blk_rd_r) * 21'(bs_eff) + 21'(off_r);

  always_ff @(posedge clk) begin
    if (fq_we) begin
      fq_mem[fq_waddr] <= fq_wdata;
    end
    fq_rd_r <= fq_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= fq_rd_r;
    end
    blk_rd_r <= blk_mem[blk_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[slot_r] <= cnt_wdata;
    end
    cnt_rd_r <= cnt_mem[in_request_slot];
  end

  // Configuration and the rewrite of the free FIFO.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_per_blk_r <= BS_W'(16);
      usable_r      <= 13'd4000;
      reserve_r     <= 12'd96;
      clr_busy_r    <= 1'b1;
      clr_idx_r     <= '0;
    end else begin
      if (cfg_hit) begin
        case (cfg_index)
          CFG_TOK_PER_BLK: tok_per_blk_r <= cfg_data[BS_W-1:0];
          CFG_USABLE:      usable_r      <= cfg_data;
          default:         reserve_r     <= cfg_data[11:0];
        endcase
        clr_busy_r <= 1'b1;
        clr_idx_r  <= '0;
      end else if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + BLK_W'(1);
        if (clr_idx_r == BLK_W'(TOTAL_BLOCKS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  // Transaction sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      req_valid_r  <= '0;
      out_valid_r  <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      free_total_r <= '0;
    end else begin
      if (st_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_hit) begin
        req_valid_r <= '0;
      end
      if (clr_busy_r) begin
        head_r       <= '0;
        tail_r       <= fill[BLK_W-1:0];
        free_total_r <= fill;
      end
      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            st_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          cnt_work_r <= cnt_eff;
          value_r    <= '0;
          if (eval_div) begin
            status_r <= ST_OK;
            st_r     <= S_DIV1;
          end else begin
            case (act_r)
              ACT_ALLOC: begin
                status_r <= vld ? ST_EXISTS : ST_BADARG;
                st_r     <= S_DONE;
              end
              ACT_APPEND_TOK: begin
                status_r <= (tok_r == '0) ? ST_BADARG : (!vld ? ST_UNKNOWN : ST_BADARG);
                st_r     <= S_DONE;
              end
              ACT_APPEND_BLK: begin
                if (free_total_r == '0) begin
                  status_r <= ST_NOFREE;
                  st_r     <= S_DONE;
                end else if (!vld) begin
                  status_r <= ST_UNKNOWN;
                  st_r     <= S_DONE;
                end else if (cnt_eff >= CNT_W'(MAX_BLOCKS_PER_REQUEST)) begin
                  status_r <= ST_FULL;
                  st_r     <= S_DONE;
                end else begin
                  status_r <= ST_OK;
                  n_r      <= CNT_W'(1);
                  st_r     <= S_POP;
                end
              end
              ACT_RELEASE: begin
                if (!vld) begin
                  status_r <= ST_UNKNOWN;
                  st_r     <= S_DONE;
                end else begin
                  status_r <= ST_OK;
                  idx_r    <= '0;
                  st_r     <= S_REL;
                end
              end
              ACT_MAP_SLOT: begin
                status_r <= !vld ? ST_UNKNOWN : ST_BADARG;
                st_r     <= S_DONE;
              end
              ACT_READ_ENTRY: begin
                if (!vld) begin
                  status_r <= ST_UNKNOWN;
                  st_r     <= S_DONE;
                end else if ({1'b0, eidx_r} >= cnt_eff) begin
                  status_r <= ST_BADARG;
                  st_r     <= S_DONE;
                end else begin
                  status_r <= ST_OK;
                  idx_r    <= {1'b0, eidx_r};
                  st_r     <= S_RDB;
                end
              end
              default: begin
                status_r <= ST_BADARG;
                st_r     <= S_DONE;
              end
            endcase
          end
        end
        S_DIV1: begin
          if (drsp.done) begin
            case (act_r)
              ACT_ALLOC: begin
                if (need > 17'(MAX_BLOCKS_PER_REQUEST)) begin
                  status_r <= ST_FULL;
                  st_r     <= S_DONE;
                end else if ({4'b0, free_total_r} < need + {5'b0, reserve_r}) begin
                  status_r <= ST_NOFREE;
                  st_r     <= S_DONE;
                end else begin
                  req_valid_r[slot_r] <= 1'b1;
                  n_r  <= need[CNT_W-1:0];
                  st_r <= S_POP;
                end
              end
              ACT_APPEND_TOK: begin
                st_r <= tok_over ? S_DIV2 : S_DONE;
              end
              default: begin
                if ({2'b0, drsp.quot} >= 17'(cnt_work_r)) begin
                  status_r <= ST_BADARG;
                  st_r     <= S_DONE;
                end else begin
                  idx_r <= drsp.quot[CNT_W-1:0];
                  off_r <= drsp.rem;
                  st_r  <= S_RDB;
                end
              end
            endcase
          end
        end
        S_DIV2: begin
          if (drsp.done) begin
            if ({4'b0, free_total_r} <= add) begin
              status_r <= ST_NOFREE;
              st_r     <= S_DONE;
            end else if (17'(cnt_work_r) + add > 17'(MAX_BLOCKS_PER_REQUEST)) begin
              status_r <= ST_FULL;
              st_r     <= S_DONE;
            end else begin
              n_r  <= add[CNT_W-1:0];
              st_r <= S_POP;
            end
          end
        end
        S_POP: begin
          head_r       <= head_r + BLK_W'(1);
          free_total_r <= free_total_r - TOT_W'(1);
          st_r         <= S_PWR;
        end
        S_PWR: begin
          cnt_work_r <= cnt_work_r + CNT_W'(1);
          n_r        <= n_r - CNT_W'(1);
          st_r       <= (n_r == CNT_W'(1)) ? S_DONE : S_POP;
        end
        S_REL: begin
          if (idx_r == cnt_work_r) begin
            req_valid_r[slot_r] <= 1'b0;
            cnt_work_r <= '0;
            st_r       <= S_DONE;
          end else begin
            idx_r <= idx_r + CNT_W'(1);
            st_r  <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (free_total_r < TOT_W'(TOTAL_BLOCKS)) begin
            tail_r       <= tail_r + BLK_W'(1);
            free_total_r <= free_total_r + TOT_W'(1);
          end
          st_r <= S_REL;
        end
        S_RDB: begin
          st_r <= (act_r == ACT_MAP_SLOT) ? S_MUL : S_RDV;
        end
        S_RDV: begin
          value_r <= VAL_W'(blk_rd_r);
          st_r    <= S_DONE;
        end
        S_MUL: begin
          value_r <= slot_addr[VAL_W-1:0];
          st_r    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            st_r <= S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  // Transaction capture and result register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r  <= in_action;
      slot_r <= in_request_slot;
      len_r  <= in_length;
      tok_r  <= in_token_count;
      eidx_r <= in_entry_index;
    end
    if (st_r == S_DONE && (!out_valid_r || out_ready)) begin
      o_status_r <= status_r;
      o_value_r  <= value_r;
      o_free_r   <= free_total_r;
      o_len_r    <= cnt_work_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = o_status_r;
  assign out_value       = o_value_r;
  assign out_free_count  = o_free_r;
  assign out_list_length = o_len_r;

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_total_r <= TOT_W'(TOTAL_BLOCKS))
    else $error("free block count exceeds the pool size");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_POP |-> free_total_r != '0)
    else $error("block popped from an empty free FIFO");

  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_PWR |-> cnt_work_r < CNT_W'(MAX_BLOCKS_PER_REQUEST))
    else $error("block list written past its capacity");

  a_no_accept_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready)
    else $error("transaction accepted during free FIFO rewrite");
`endif

endmodule

// ===== rtl/pcba_div.sv =====
// ----------------------------------------------------------------------------
// pcba_div
// Restoring divider, one quotient bit per cycle, for token counts by block size.
// ----------------------------------------------------------------------------
module pcba_div (
  input  logic               clk,
  input  logic               rst_n,
  input  pcba_pkg::div_req_t req,
  output pcba_pkg::div_rsp_t rsp
);
  import pcba_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [3:0]       step_r;
  logic [LEN_W-1:0] quo_r;
  logic [BS_W-1:0]  rem_r;
  logic [BS_W-1:0]  dvs_r;
  logic [BS_W:0]    rem_sh;
  logic             ge;
  logic [BS_W:0]    rem_sub;

  assign rem_sh  = {rem_r, quo_r[LEN_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= !req.start && busy_r && (step_r == 4'(LEN_W - 1));
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 4'd1;
        if (step_r == 4'(LEN_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[LEN_W-2:0], ge};
      rem_r <= ge ? rem_sub[BS_W-1:0] : rem_sh[BS_W-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule
